// ===== rtl/core/ipb_pkg.sv =====
// Shared types, constants and a helper function of the pixel binning core.
package ipb_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 4096;
  localparam int unsigned DEF_MAX_FACTOR = 64;
  localparam int unsigned DEF_PIXEL_BITS = 32;

  localparam int unsigned PIX_W        = 32;
  localparam int unsigned ACC_W        = 44;
  localparam int unsigned PRS_W        = 38;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 13;
  localparam int unsigned FACTOR_REG_W = 7;
  localparam int unsigned SIZE_REG_W   = 13;
  localparam int unsigned PWID_REG_W   = 2;

  localparam logic [PWID_REG_W-1:0] PW_8BIT  = 2'd0;
  localparam logic [PWID_REG_W-1:0] PW_16BIT = 2'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_FACTOR     = 3'd0,
    CFG_Y_FACTOR     = 3'd1,
    CFG_MODE         = 3'd2,
    CFG_PIXEL_WIDTH  = 3'd3,
    CFG_IMAGE_WIDTH  = 3'd4,
    CFG_IMAGE_HEIGHT = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    DIV_COL,
    DIV_LINE,
    DIV_MEAN
  } div_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COL_GO,
    ST_COL_WAIT,
    ST_LIN_GO,
    ST_LIN_WAIT,
    ST_EVAL,
    ST_CHK,
    ST_ACC,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_EMIT,
    ST_ADV
  } state_t;

  typedef struct packed {
    logic     latch;
    logic     div_go;
    div_sel_t div_sel;
    logic     cap_col;
    logic     eval;
    logic     rd;
    logic     acc;
    logic     emit;
    logic     adv;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic bin_full;
    logic emit_bin;
    logic mean;
    logic out_free;
  } sts_t;

  // Mask of the pixel bits that the selected pixel type holds.
  function automatic logic [PIX_W-1:0] type_mask(input logic [PWID_REG_W-1:0] pw,
                                                 input int unsigned pbits);
    int unsigned b;
    b = (pw == PW_8BIT) ? 8 : (pw == PW_16BIT) ? 16 : 32;
    if (b > pbits) b = pbits;
    return {PIX_W{1'b1}} >> (PIX_W - b);
  endfunction

endpackage

// ===== rtl/core/ipb_ram.sv =====
// Generic single-port RAM with registered read data.
module ipb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/ipb_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module ipb_div #(
  parameter int unsigned DW = 44,
  parameter int unsigned VW = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] quot,
  output logic [VW-1:0] rem
);

  localparam int unsigned CNTW = $clog2(DW + 1);

  logic [DW-1:0]   q_r, q_nxt;
  logic [VW-1:0]   r_r, r_nxt;
  logic [VW-1:0]   d_r;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic [VW:0]     trial;
  logic            fits;

  assign trial = {r_r, q_r[DW-1]};
  assign fits  = trial >= {1'b0, d_r};

  always_comb begin
    q_nxt    = q_r;
    r_nxt    = r_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt    = dividend;
      r_nxt    = '0;
      cnt_nxt  = CNTW'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[DW-2:0], fits};
      r_nxt   = fits ? VW'(trial - {1'b0, d_r}) : VW'(trial);
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNTW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    r_r <= r_nxt;
    if (start) begin
      d_r <= divisor;
    end
  end

  assign busy = busy_r;
  assign quot = q_r;
  assign rem  = r_r;

endmodule

// ===== rtl/core/ipb_dp.sv =====
// Datapath: configuration, positions, bin sums, line store, divider and result register.
module ipb_dp #(
  parameter int unsigned MAX_WIDTH  = ipb_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_FACTOR = ipb_pkg::DEF_MAX_FACTOR,
  parameter int unsigned PIXEL_BITS = ipb_pkg::DEF_PIXEL_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ipb_pkg::cmd_t                     cmd,
  output ipb_pkg::sts_t                     sts,
  input  logic                              cfg_valid,
  input  logic [ipb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ipb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic [ipb_pkg::PIX_W-1:0]         in_pixel_value,
  input  logic                              in_frame_start,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ipb_pkg::PIX_W-1:0]         out_binned_value,
  output logic                              out_row_end,
  output logic                              out_frame_end
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned FW = $clog2(MAX_FACTOR + 1);
  localparam int unsigned LW = $clog2(MAX_FACTOR);
  localparam int unsigned VW = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
  localparam int unsigned EW = $clog2(MAX_WIDTH + 2 * MAX_FACTOR + 1);
  localparam int unsigned ACC_W = ipb_pkg::ACC_W;
  localparam int unsigned PRS_W = ipb_pkg::PRS_W;
  localparam int unsigned PIX_W = ipb_pkg::PIX_W;

  logic [ipb_pkg::FACTOR_REG_W-1:0] xf_reg_r, yf_reg_r;
  logic                             mode_r;
  logic [ipb_pkg::PWID_REG_W-1:0]   pw_r;
  logic [ipb_pkg::SIZE_REG_W-1:0]   iw_r, ih_r;

  logic [FW-1:0] xf, yf;
  logic [WW-1:0] w, h;
  logic [PIX_W-1:0] mask;

  logic [AW-1:0]    col_r, col_nxt, line_r, line_nxt, bc_r;
  logic [FW-1:0]    cib_r, cib_nxt, crem_r;
  logic [LW-1:0]    lib_r, lib_nxt;
  logic [PRS_W-1:0] prs_r, prs_nxt;
  logic [PIX_W-1:0] pix_r;
  logic             inr_r, re_r, fe_r;
  logic [ACC_W-1:0] acc_r, acc_c, mem_q;

  logic [EW-1:0]    bstart, lstart;
  logic             inr_c, re_c, fe_c;

  logic [ACC_W-1:0] div_quot;
  logic [VW-1:0]    div_rem, div_dvs;
  logic [ACC_W-1:0] div_dvd;
  logic             div_busy;
  logic [2*FW-1:0]  area;

  logic             out_valid_r;
  logic [PIX_W-1:0] out_val_r, out_val_c;
  logic             out_re_r, out_fe_r;
  logic             out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xf_reg_r <= ipb_pkg::FACTOR_REG_W'(1);
      yf_reg_r <= ipb_pkg::FACTOR_REG_W'(1);
      mode_r   <= 1'b0;
      pw_r     <= ipb_pkg::PW_16BIT;
      iw_r     <= ipb_pkg::SIZE_REG_W'(4096);
      ih_r     <= ipb_pkg::SIZE_REG_W'(4096);
    end else if (cfg_valid) begin
      unique case (ipb_pkg::cfg_idx_t'(cfg_index))
        ipb_pkg::CFG_X_FACTOR:     xf_reg_r <= cfg_wdata[ipb_pkg::FACTOR_REG_W-1:0];
        ipb_pkg::CFG_Y_FACTOR:     yf_reg_r <= cfg_wdata[ipb_pkg::FACTOR_REG_W-1:0];
        ipb_pkg::CFG_MODE:         mode_r   <= cfg_wdata[0];
        ipb_pkg::CFG_PIXEL_WIDTH:  pw_r     <= cfg_wdata[ipb_pkg::PWID_REG_W-1:0];
        ipb_pkg::CFG_IMAGE_WIDTH:  iw_r     <= cfg_wdata[ipb_pkg::SIZE_REG_W-1:0];
        ipb_pkg::CFG_IMAGE_HEIGHT: ih_r     <= cfg_wdata[ipb_pkg::SIZE_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Out-of-range settings are clamped into the supported range.
  always_comb begin
    xf = (xf_reg_r == '0) ? FW'(1) :
         (32'(xf_reg_r) > MAX_FACTOR) ? FW'(MAX_FACTOR) : FW'(xf_reg_r);
    yf = (yf_reg_r == '0) ? FW'(1) :
         (32'(yf_reg_r) > MAX_FACTOR) ? FW'(MAX_FACTOR) : FW'(yf_reg_r);
    w  = (iw_r == '0) ? WW'(1) : (32'(iw_r) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(iw_r);
    h  = (ih_r == '0) ? WW'(1) : (32'(ih_r) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(ih_r);
    mask = ipb_pkg::type_mask(pw_r, PIXEL_BITS);
  end

  assign area = xf * yf;

  always_comb begin
    unique case (cmd.div_sel)
      ipb_pkg::DIV_COL: begin
        div_dvd = ACC_W'(col_r);
        div_dvs = VW'(xf);
      end
      ipb_pkg::DIV_LINE: begin
        div_dvd = ACC_W'(line_r);
        div_dvs = VW'(yf);
      end
      ipb_pkg::DIV_MEAN: begin
        div_dvd = acc_r;
        div_dvs = VW'(area);
      end
      default: begin
        div_dvd = acc_r;
        div_dvs = VW'(area);
      end
    endcase
  end

  ipb_div #(
    .DW (ACC_W),
    .VW (VW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_go),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // A pixel counts when its whole bin fits inside the image.
  always_comb begin
    bstart = EW'(col_r) - EW'(crem_r);
    lstart = EW'(line_r) - EW'(div_rem[FW-1:0]);
    inr_c  = (bstart + EW'(xf) <= EW'(w)) && (lstart + EW'(yf) <= EW'(h));
    re_c   = (bstart + EW'(xf) + EW'(xf)) > EW'(w);
    fe_c   = re_c && ((lstart + EW'(yf) + EW'(yf)) > EW'(h));
  end

  assign acc_c = (lib_r == '0) ? ACC_W'(prs_r) : mem_q + ACC_W'(prs_r);

  ipb_ram #(
    .WIDTH (ACC_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (cmd.acc),
    .re    (cmd.rd),
    .addr  (bc_r),
    .wdata (acc_c),
    .rdata (mem_q)
  );

  always_comb begin
    col_nxt  = col_r;
    line_nxt = line_r;
    cib_nxt  = cib_r;
    lib_nxt  = lib_r;
    prs_nxt  = prs_r;
    if (cmd.latch && in_frame_start) begin
      col_nxt  = '0;
      line_nxt = '0;
      cib_nxt  = '0;
      lib_nxt  = '0;
      prs_nxt  = '0;
    end
    if (cmd.eval && inr_c) begin
      prs_nxt = prs_r + PRS_W'(pix_r & mask);
      cib_nxt = cib_r + 1'b1;
    end
    if (cmd.acc) begin
      prs_nxt = '0;
      cib_nxt = '0;
    end
    if (cmd.adv) begin
      if (WW'(col_r) + 1'b1 >= w) begin
        col_nxt = '0;
        cib_nxt = '0;
        prs_nxt = '0;
        lib_nxt = (FW'(lib_r) + 1'b1 >= yf) ? '0 : lib_r + 1'b1;
        if (WW'(line_r) + 1'b1 >= h) begin
          line_nxt = '0;
          lib_nxt  = '0;
        end else begin
          line_nxt = line_r + 1'b1;
        end
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      line_r <= '0;
      cib_r  <= '0;
      lib_r  <= '0;
      prs_r  <= '0;
    end else begin
      col_r  <= col_nxt;
      line_r <= line_nxt;
      cib_r  <= cib_nxt;
      lib_r  <= lib_nxt;
      prs_r  <= prs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      pix_r <= in_pixel_value;
    end
    if (cmd.cap_col) begin
      crem_r <= div_rem[FW-1:0];
      bc_r   <= div_quot[AW-1:0];
    end
    if (cmd.eval) begin
      inr_r <= inr_c;
      re_r  <= re_c;
      fe_r  <= fe_c;
    end
    if (cmd.acc) begin
      acc_r <= acc_c;
    end
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign out_val_c = mode_r ? div_quot[PIX_W-1:0] :
                     (acc_r > ACC_W'(mask)) ? mask : acc_r[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_val_r <= out_val_c;
      out_re_r  <= re_r;
      out_fe_r  <= fe_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_binned_value = out_val_r;
  assign out_row_end      = out_re_r;
  assign out_frame_end    = out_fe_r;

  assign sts.div_busy = div_busy;
  assign sts.bin_full = inr_r && (cib_r >= xf);
  assign sts.emit_bin = (FW'(lib_r) + 1'b1) >= yf;
  assign sts.mean     = mode_r;
  assign sts.out_free = out_free;

endmodule

// ===== rtl/core/ipb_ctrl.sv =====
// Controller state machine that sequences one pixel through the datapath.
module ipb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ipb_pkg::sts_t sts,
  output ipb_pkg::cmd_t cmd
);

  ipb_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ipb_pkg::ST_IDLE:      if (in_valid) state_nxt = ipb_pkg::ST_COL_GO;
      ipb_pkg::ST_COL_GO:    state_nxt = ipb_pkg::ST_COL_WAIT;
      ipb_pkg::ST_COL_WAIT:  if (!sts.div_busy) state_nxt = ipb_pkg::ST_LIN_GO;
      ipb_pkg::ST_LIN_GO:    state_nxt = ipb_pkg::ST_LIN_WAIT;
      ipb_pkg::ST_LIN_WAIT:  if (!sts.div_busy) state_nxt = ipb_pkg::ST_EVAL;
      ipb_pkg::ST_EVAL:      state_nxt = ipb_pkg::ST_CHK;
      ipb_pkg::ST_CHK: begin
        state_nxt = sts.bin_full ? ipb_pkg::ST_ACC : ipb_pkg::ST_ADV;
      end
      ipb_pkg::ST_ACC: begin
        priority if (!sts.emit_bin) state_nxt = ipb_pkg::ST_ADV;
        else if (sts.mean)          state_nxt = ipb_pkg::ST_MEAN_GO;
        else                        state_nxt = ipb_pkg::ST_EMIT;
      end
      ipb_pkg::ST_MEAN_GO:   state_nxt = ipb_pkg::ST_MEAN_WAIT;
      ipb_pkg::ST_MEAN_WAIT: if (!sts.div_busy) state_nxt = ipb_pkg::ST_EMIT;
      ipb_pkg::ST_EMIT:      if (sts.out_free) state_nxt = ipb_pkg::ST_ADV;
      ipb_pkg::ST_ADV:       state_nxt = ipb_pkg::ST_IDLE;
      default:               state_nxt = ipb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.div_sel = ipb_pkg::DIV_COL;
    in_stall    = 1'b1;
    unique case (state_r)
      ipb_pkg::ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.latch = in_valid;
      end
      ipb_pkg::ST_COL_GO:    cmd.div_go = 1'b1;
      ipb_pkg::ST_COL_WAIT:  cmd.cap_col = !sts.div_busy;
      ipb_pkg::ST_LIN_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = ipb_pkg::DIV_LINE;
      end
      ipb_pkg::ST_LIN_WAIT:  cmd.div_sel = ipb_pkg::DIV_LINE;
      ipb_pkg::ST_EVAL:      cmd.eval = 1'b1;
      ipb_pkg::ST_CHK:       cmd.rd = sts.bin_full;
      ipb_pkg::ST_ACC:       cmd.acc = 1'b1;
      ipb_pkg::ST_MEAN_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = ipb_pkg::DIV_MEAN;
      end
      ipb_pkg::ST_MEAN_WAIT: cmd.div_sel = ipb_pkg::DIV_MEAN;
      ipb_pkg::ST_EMIT: begin
        cmd.div_sel = ipb_pkg::DIV_MEAN;
        cmd.emit    = sts.out_free;
      end
      ipb_pkg::ST_ADV:       cmd.adv = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ipb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/image_pixel_binning_core.sv =====
// Top level of the pixel binning core: controller, datapath and port wiring.
// Pixels arrive in raster order and are summed over x_factor by y_factor bins;
// one beat leaves per full bin, as a saturated sum or a truncated mean. Each
// pixel holds off the input until the controller is back in idle; a pixel that
// closes a bin also waits for the output register to free, and in mean mode for
// the mean division. The pace is set by the shared one-bit-per-cycle divider,
// which finds the bin column and line offsets of every pixel and, in mean mode,
// the mean of every bin. The line store needs no clearing pass. A finished beat
// waits in the output register while the next pixel is taken.
module image_pixel_binning_core #(
  parameter int unsigned MAX_WIDTH  = ipb_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_FACTOR = ipb_pkg::DEF_MAX_FACTOR,
  parameter int unsigned PIXEL_BITS = ipb_pkg::DEF_PIXEL_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ipb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ipb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ipb_pkg::PIX_W-1:0]       in_pixel_value,
  input  logic                            in_frame_start,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ipb_pkg::PIX_W-1:0]       out_binned_value,
  output logic                            out_row_end,
  output logic                            out_frame_end
);

  ipb_pkg::cmd_t cmd;
  ipb_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  ipb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ipb_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_FACTOR (MAX_FACTOR),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_pixel_value   (in_pixel_value),
    .in_frame_start   (in_frame_start),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_binned_value (out_binned_value),
    .out_row_end      (out_row_end),
    .out_frame_end    (out_frame_end)
  );

endmodule
